// File: rtl/rlhc_pkg.sv
// ----------------------------------------------------------------------------
// rlhc_pkg
// types, constants and register defaults for the resolution level control
// ----------------------------------------------------------------------------
package rlhc_pkg;

    localparam int LEVELS = 4;
    localparam logic [1:0] LEVEL_MAX = 2'(LEVELS - 1);
    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LOAD_THRESHOLDS    = 4'd0,
        REG_BITRATE_DOWN_LIMIT = 4'd1,
        REG_BITRATE_UP_LIMIT   = 4'd2,
        REG_FRAME_COUNTS       = 4'd3,
        REG_BITRATE_FLOOR      = 4'd4,
        REG_NATIVE_SIZE        = 4'd5,
        REG_FLOOR_SIZE         = 4'd6,
        REG_SCALE_TABLE        = 4'd7
    } t_reg_index;

    localparam logic [31:0] RST_LOAD_THRESHOLDS    = 32'd8388838;
    localparam logic [31:0] RST_BITRATE_DOWN_LIMIT = 32'd2000000;
    localparam logic [31:0] RST_BITRATE_UP_LIMIT   = 32'd5000000;
    localparam logic [15:0] RST_FRAME_COUNTS       = 16'd7683;
    localparam logic [31:0] RST_BITRATE_FLOOR      = 32'd500000;
    localparam logic [31:0] RST_NATIVE_SIZE        = 32'd70780800;
    localparam logic [31:0] RST_FLOOR_SIZE         = 32'd47187200;
    localparam logic [63:0] RST_SCALE_TABLE        = 64'd4611779843598614528;

    typedef struct packed {
        logic [31:0] load_thresholds;
        logic [31:0] bitrate_down_limit;
        logic [31:0] bitrate_up_limit;
        logic [15:0] frame_counts;
        logic [31:0] bitrate_floor;
        logic [31:0] native_size;
        logic [31:0] floor_size;
        logic [63:0] scale_table;
    } t_cfg;

    typedef struct packed {
        logic [19:0] encode_time_us;
        logic [19:0] frame_budget_us;
        logic [31:0] measured_bitrate;
    } t_in;

    typedef struct packed {
        logic [1:0]  quality_level;
        logic        level_changed;
        logic [15:0] target_width;
        logic [15:0] target_height;
        logic [31:0] target_bitrate;
    } t_out;

    // classified frame handed from the front to the back
    typedef struct packed {
        logic        want_down;
        logic        want_up;
        logic [31:0] rate;
    } t_cls;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_W,
        ST_MUL_H,
        ST_MUL_B1,
        ST_MUL_B2,
        ST_FIN
    } t_state;

endpackage

// File: rtl/rlhc_front.sv
// ----------------------------------------------------------------------------
// rlhc_front
// takes frame reports and classifies them into step down / step up wishes
// ----------------------------------------------------------------------------
module rlhc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rlhc_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rlhc_pkg::t_in   i_in_data,
    output logic            o_push,
    output rlhc_pkg::t_cls  o_push_data,
    input  logic            i_q_ready
);

    logic           r_vld;
    rlhc_pkg::t_in  r_item;

    logic [27:0] w_time256;
    logic [35:0] w_prod_down;
    logic [35:0] w_prod_up;
    logic        w_over;
    logic        w_under;
    logic [15:0] w_thr_down;
    logic [15:0] w_thr_up;

    assign w_thr_down = i_cfg.load_thresholds[15:0];
    assign w_thr_up   = i_cfg.load_thresholds[31:16];

    assign o_push     = r_vld && i_q_ready;
    assign o_in_ready = !r_vld || i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_vld <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_data;
        end
    end

    // load compare by cross multiplication: time*256 against threshold*budget
    always_comb begin
        w_time256   = {r_item.encode_time_us, 8'd0};
        w_prod_down = 36'(w_thr_down) * 36'(r_item.frame_budget_us);
        w_prod_up   = 36'(w_thr_up) * 36'(r_item.frame_budget_us);
        if (r_item.frame_budget_us != 20'd0) begin
            w_over  = {8'd0, w_time256} > w_prod_down;
            w_under = {8'd0, w_time256} < w_prod_up;
        end else begin
            w_over  = 1'b0;
            w_under = w_thr_up != 16'd0;
        end
        o_push_data.rate      = r_item.measured_bitrate;
        o_push_data.want_down = w_over ||
            (r_item.measured_bitrate != 32'd0 &&
             r_item.measured_bitrate < i_cfg.bitrate_down_limit);
        o_push_data.want_up   = w_under &&
            (r_item.measured_bitrate >= i_cfg.bitrate_up_limit);
    end

endmodule

// File: rtl/rlhc_queue.sv
// ----------------------------------------------------------------------------
// rlhc_queue
// short fifo of classified frames between the front and the back
// ----------------------------------------------------------------------------
module rlhc_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rlhc_pkg::t_cls  i_push_data,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output rlhc_pkg::t_cls  o_pop_data
);

    localparam int PTR_W = $clog2(rlhc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rlhc_pkg::QUEUE_DEPTH + 1);

    rlhc_pkg::t_cls r_mem [rlhc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_ready    = r_count != CNT_W'(rlhc_pkg::QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// File: rtl/rlhc_back.sv
// ----------------------------------------------------------------------------
// rlhc_back
// level hysteresis, then targets through one shared 33x16 multiplier
// ----------------------------------------------------------------------------
module rlhc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rlhc_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  rlhc_pkg::t_cls  i_q_data,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rlhc_pkg::t_out  o_out_data
);

    rlhc_pkg::t_state r_state, n_state;
    logic [1:0]  r_level, n_level;
    logic [7:0]  r_ds, n_ds;
    logic [7:0]  r_us, n_us;
    logic        r_changed, n_changed;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_scale, n_scale;
    logic [48:0] r_prod, n_prod;
    logic [15:0] r_tw, n_tw;
    logic [15:0] r_th, n_th;
    logic        r_out_vld, n_out_vld;
    rlhc_pkg::t_out r_out, n_out;

    logic [32:0] w_mul_a;
    logic [48:0] w_mul_p;
    logic [7:0]  w_streak;
    logic [7:0]  w_cnt_down;
    logic [7:0]  w_cnt_up;
    logic [33:0] w_br;
    logic [31:0] w_br_sat;

    assign w_cnt_down = i_cfg.frame_counts[7:0];
    assign w_cnt_up   = i_cfg.frame_counts[15:8];

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // shifted product, saturated, cleared to even, raised to the minimum
    function automatic logic [15:0] dim_of(input logic [16:0] v, input logic [15:0] minimum);
        logic [15:0] d;
        d = (v > 17'h0ffff) ? 16'hffff : v[15:0];
        d = {d[15:1], 1'b0};
        if (d < minimum) begin
            d = minimum;
        end
        return d;
    endfunction

    assign w_mul_p = 49'(w_mul_a) * 49'(r_scale);
    assign w_br    = r_prod[48:15];
    assign w_br_sat = (w_br > 34'h0ffffffff) ? 32'hffffffff : w_br[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rlhc_pkg::ST_IDLE;
            r_level   <= 2'd0;
            r_ds      <= 8'd0;
            r_us      <= 8'd0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_level   <= n_level;
            r_ds      <= n_ds;
            r_us      <= n_us;
            r_out_vld <= n_out_vld;
        end
        r_changed <= n_changed;
        r_rate    <= n_rate;
        r_scale   <= n_scale;
        r_prod    <= n_prod;
        r_tw      <= n_tw;
        r_th      <= n_th;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_level   = r_level;
        n_ds      = r_ds;
        n_us      = r_us;
        n_changed = r_changed;
        n_rate    = r_rate;
        n_scale   = r_scale;
        n_prod    = r_prod;
        n_tw      = r_tw;
        n_th      = r_th;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_out_ready;
        o_pop     = 1'b0;
        w_mul_a   = 33'd0;
        w_streak  = 8'd0;

        case (r_state)
            rlhc_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop     = 1'b1;
                    n_rate    = i_q_data.rate;
                    n_changed = 1'b0;
                    if (i_q_data.want_down && r_level < rlhc_pkg::LEVEL_MAX) begin
                        w_streak = (r_ds == 8'hff) ? r_ds : r_ds + 8'd1;
                        n_us     = 8'd0;
                        n_ds     = w_streak;
                        if (w_streak >= w_cnt_down) begin
                            n_level   = r_level + 2'd1;
                            n_ds      = 8'd0;
                            n_changed = 1'b1;
                        end
                    end else if (i_q_data.want_up && r_level != 2'd0) begin
                        w_streak = (r_us == 8'hff) ? r_us : r_us + 8'd1;
                        n_ds     = 8'd0;
                        n_us     = w_streak;
                        if (w_streak >= w_cnt_up) begin
                            n_level   = r_level - 2'd1;
                            n_us      = 8'd0;
                            n_changed = 1'b1;
                        end
                    end else begin
                        n_ds = 8'd0;
                        n_us = 8'd0;
                    end
                    n_scale = i_cfg.scale_table[{n_level, 4'd0} +: 16];
                    n_state = rlhc_pkg::ST_MUL_W;
                end
            end
            rlhc_pkg::ST_MUL_W: begin
                w_mul_a = {17'd0, i_cfg.native_size[15:0]};
                n_prod  = w_mul_p;
                n_state = rlhc_pkg::ST_MUL_H;
            end
            rlhc_pkg::ST_MUL_H: begin
                w_mul_a = {17'd0, i_cfg.native_size[31:16]};
                n_tw    = dim_of(r_prod[31:15], i_cfg.floor_size[15:0]);
                n_prod  = w_mul_p;
                n_state = rlhc_pkg::ST_MUL_B1;
            end
            rlhc_pkg::ST_MUL_B1: begin
                w_mul_a = {1'b0, r_rate};
                n_th    = dim_of(r_prod[31:15], i_cfg.floor_size[31:16]);
                n_prod  = w_mul_p;
                n_state = rlhc_pkg::ST_MUL_B2;
            end
            rlhc_pkg::ST_MUL_B2: begin
                // second factor applied to the already floored first product
                w_mul_a = r_prod[47:15];
                n_prod  = w_mul_p;
                n_state = rlhc_pkg::ST_FIN;
            end
            rlhc_pkg::ST_FIN: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld            = 1'b1;
                    n_out.quality_level  = r_level;
                    n_out.level_changed  = r_changed;
                    n_out.target_width   = r_tw;
                    n_out.target_height  = r_th;
                    n_out.target_bitrate = (w_br_sat < i_cfg.bitrate_floor) ?
                                           i_cfg.bitrate_floor : w_br_sat;
                    n_state              = rlhc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rlhc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/resolution_level_hysteresis_control.sv
// ----------------------------------------------------------------------------
// resolution_level_hysteresis_control
// per-frame downscale level control with streak hysteresis and targets
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | payload
//  in      | input     | i_in_valid / o_in_ready    | i_in_data  (rlhc_pkg::t_in)
//  out     | output    | o_out_valid / i_out_ready  | o_out_data (rlhc_pkg::t_out)
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  a frame is registered on acceptance, classified from that register and queued
//  (two entries); the back steps through the level update, the shared multiplier
//  (width, height, two bitrate factors) and final saturation for each frame
//  the back sequencer takes a new frame only once the last has left its final state
//  synchronous reset restores register defaults, level 0 and clear streaks
//  each side stalls on its own; the output register holds a result until taken
// ----------------------------------------------------------------------------
module resolution_level_hysteresis_control (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  rlhc_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output rlhc_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rlhc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [rlhc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    rlhc_pkg::t_cfg r_cfg;

    logic           w_push;
    rlhc_pkg::t_cls w_push_data;
    logic           w_q_ready;
    logic           w_pop;
    logic           w_q_valid;
    rlhc_pkg::t_cls w_pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_thresholds    <= rlhc_pkg::RST_LOAD_THRESHOLDS;
            r_cfg.bitrate_down_limit <= rlhc_pkg::RST_BITRATE_DOWN_LIMIT;
            r_cfg.bitrate_up_limit   <= rlhc_pkg::RST_BITRATE_UP_LIMIT;
            r_cfg.frame_counts       <= rlhc_pkg::RST_FRAME_COUNTS;
            r_cfg.bitrate_floor      <= rlhc_pkg::RST_BITRATE_FLOOR;
            r_cfg.native_size        <= rlhc_pkg::RST_NATIVE_SIZE;
            r_cfg.floor_size         <= rlhc_pkg::RST_FLOOR_SIZE;
            r_cfg.scale_table        <= rlhc_pkg::RST_SCALE_TABLE;
        end else if (i_cfg_valid) begin
            // unknown indexes fall through and are ignored
            case (i_cfg_index)
                rlhc_pkg::REG_LOAD_THRESHOLDS:    r_cfg.load_thresholds    <= i_cfg_data[31:0];
                rlhc_pkg::REG_BITRATE_DOWN_LIMIT: r_cfg.bitrate_down_limit <= i_cfg_data[31:0];
                rlhc_pkg::REG_BITRATE_UP_LIMIT:   r_cfg.bitrate_up_limit   <= i_cfg_data[31:0];
                rlhc_pkg::REG_FRAME_COUNTS:       r_cfg.frame_counts       <= i_cfg_data[15:0];
                rlhc_pkg::REG_BITRATE_FLOOR:      r_cfg.bitrate_floor      <= i_cfg_data[31:0];
                rlhc_pkg::REG_NATIVE_SIZE:        r_cfg.native_size        <= i_cfg_data[31:0];
                rlhc_pkg::REG_FLOOR_SIZE:         r_cfg.floor_size         <= i_cfg_data[31:0];
                rlhc_pkg::REG_SCALE_TABLE:        r_cfg.scale_table        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rlhc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_q_ready   (w_q_ready)
    );

    rlhc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_ready     (w_q_ready),
        .i_pop       (w_pop),
        .o_valid     (w_q_valid),
        .o_pop_data  (w_pop_data)
    );

    rlhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_data    (w_pop_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: bench/resolution_level_hysteresis_control_test.sv
// ----------------------------------------------------------------------------
// resolution_level_hysteresis_control_test
// self-checking bench for the resolution level control: a directed table of
// frame reports and register writes, then randomized phases of streaky frame
// traffic under several register settings, each result checked field by
// field against typed values or a cycle-free model of level, streaks and targets
// ----------------------------------------------------------------------------
module resolution_level_hysteresis_control_test;

    import rlhc_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          HOLD_AT_FRAME = 400;
    localparam int          SETTLE_CYCLES = 40;
    localparam logic [3:0]  REG_UNMAPPED  = 4'd9;

    typedef enum logic [1:0] {ROW_FRAME, ROW_TYPED, ROW_REG} t_row_kind;
    typedef enum logic [1:0] {PHASE_DEFAULTS, PHASE_RANDOM, PHASE_ZEROS, PHASE_ONES} t_phase;
    typedef enum logic [1:0] {PUSH_DOWN, PUSH_UP, PUSH_KNEE, PUSH_NOISE} t_push;

    typedef struct {
        t_row_kind   kind;
        logic [3:0]  reg_index;
        logic [63:0] reg_value;
        t_in         frame;
        t_out        typed_result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // register copies and control state of the model
    logic [31:0] cfg_load_thr     = RST_LOAD_THRESHOLDS;
    logic [31:0] cfg_down_limit   = RST_BITRATE_DOWN_LIMIT;
    logic [31:0] cfg_up_limit     = RST_BITRATE_UP_LIMIT;
    logic [15:0] cfg_frame_counts = RST_FRAME_COUNTS;
    logic [31:0] cfg_rate_floor   = RST_BITRATE_FLOOR;
    logic [31:0] cfg_native       = RST_NATIVE_SIZE;
    logic [31:0] cfg_floor_size   = RST_FLOOR_SIZE;
    logic [63:0] cfg_scale_table  = RST_SCALE_TABLE;
    logic [1:0]  cur_level        = '0;
    logic [7:0]  down_run         = '0;
    logic [7:0]  up_run           = '0;

    t_out pending_results[$];
    t_row directed_rows[$];
    int   mismatches   = 0;
    int   frames_sent  = 0;
    int   idle_odds    = 4;
    bit   hold_request = 1'b0;

    resolution_level_hysteresis_control DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic logic [15:0] scaled_dim(logic [15:0] native, logic [15:0] minimum,
                                               logic [15:0] s);
        logic [63:0] v;
        v = (64'(native) * 64'(s)) >> 15;
        if (v > 64'hFFFF) v = 64'hFFFF;
        v[0] = 1'b0;
        if (v < 64'(minimum)) v = 64'(minimum);
        return v[15:0];
    endfunction

    function automatic t_out frame_decision(t_in f);
        logic [63:0] t_scaled;
        logic [63:0] down_bound;
        logic [63:0] up_bound;
        logic [63:0] rate_out;
        logic        over;
        logic        under;
        logic        want_down;
        logic        want_up;
        logic        changed;
        logic [15:0] s;
        t_out        r;
        t_scaled   = 64'(f.encode_time_us) << 8;
        down_bound = 64'(cfg_load_thr[15:0]) * 64'(f.frame_budget_us);
        up_bound   = 64'(cfg_load_thr[31:16]) * 64'(f.frame_budget_us);
        if (f.frame_budget_us != '0) begin
            over  = t_scaled > down_bound;
            under = t_scaled < up_bound;
        end else begin
            // zero budget reads as zero load
            over  = 1'b0;
            under = cfg_load_thr[31:16] != '0;
        end
        want_down = over || (f.measured_bitrate != '0 && f.measured_bitrate < cfg_down_limit);
        want_up   = under && f.measured_bitrate >= cfg_up_limit;
        changed   = 1'b0;
        if (want_down && cur_level < LEVEL_MAX) begin
            if (down_run != 8'hFF) down_run++;
            up_run = '0;
            if (down_run >= cfg_frame_counts[7:0]) begin
                cur_level++;
                down_run = '0;
                changed  = 1'b1;
            end
        end else if (want_up && cur_level != '0) begin
            if (up_run != 8'hFF) up_run++;
            down_run = '0;
            if (up_run >= cfg_frame_counts[15:8]) begin
                cur_level--;
                up_run  = '0;
                changed = 1'b1;
            end
        end else begin
            down_run = '0;
            up_run   = '0;
        end
        s = cfg_scale_table[16*cur_level +: 16];
        r.quality_level = cur_level;
        r.level_changed = changed;
        r.target_width  = scaled_dim(cfg_native[15:0], cfg_floor_size[15:0], s);
        r.target_height = scaled_dim(cfg_native[31:16], cfg_floor_size[31:16], s);
        rate_out = (((64'(f.measured_bitrate) * 64'(s)) >> 15) * 64'(s)) >> 15;
        if (rate_out > 64'hFFFF_FFFF) rate_out = 64'hFFFF_FFFF;
        if (rate_out < 64'(cfg_rate_floor)) rate_out = 64'(cfg_rate_floor);
        r.target_bitrate = rate_out[31:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    // leaves valid high so a back-to-back transaction needs no second assignment
    task automatic offer_frame(t_in f, bit use_typed, t_out typed_result);
        t_out want;
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (!o_in_ready);
        want = frame_decision(f);
        pending_results.push_back(use_typed ? typed_result : want);
        frames_sent++;
    endtask

    task automatic sender_gap();
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic drain_frames();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_LOAD_THRESHOLDS:    cfg_load_thr     = value[31:0];
            REG_BITRATE_DOWN_LIMIT: cfg_down_limit   = value[31:0];
            REG_BITRATE_UP_LIMIT:   cfg_up_limit     = value[31:0];
            REG_FRAME_COUNTS:       cfg_frame_counts = value[15:0];
            REG_BITRATE_FLOOR:      cfg_rate_floor   = value[31:0];
            REG_NATIVE_SIZE:        cfg_native       = value[31:0];
            REG_FLOOR_SIZE:         cfg_floor_size   = value[31:0];
            REG_SCALE_TABLE:        cfg_scale_table  = value;
            default: ;
        endcase
    endtask

    task automatic program_phase(t_phase kind);
        logic [63:0] vals [0:REG_SCALE_TABLE];
        drain_frames();
        case (kind)
            PHASE_DEFAULTS: begin
                vals[REG_LOAD_THRESHOLDS]    = 64'(RST_LOAD_THRESHOLDS);
                vals[REG_BITRATE_DOWN_LIMIT] = 64'(RST_BITRATE_DOWN_LIMIT);
                vals[REG_BITRATE_UP_LIMIT]   = 64'(RST_BITRATE_UP_LIMIT);
                vals[REG_FRAME_COUNTS]       = 64'(RST_FRAME_COUNTS);
                vals[REG_BITRATE_FLOOR]      = 64'(RST_BITRATE_FLOOR);
                vals[REG_NATIVE_SIZE]        = 64'(RST_NATIVE_SIZE);
                vals[REG_FLOOR_SIZE]         = 64'(RST_FLOOR_SIZE);
                vals[REG_SCALE_TABLE]        = RST_SCALE_TABLE;
            end
            PHASE_ZEROS: foreach (vals[i]) vals[i] = '0;
            PHASE_ONES:  foreach (vals[i]) vals[i] = '1;
            default: begin
                // plausible settings with junk in the unused upper bits, some fully randomized
                vals[REG_LOAD_THRESHOLDS]    = {$urandom, 16'($urandom_range(0, 300)),
                                                16'($urandom_range(100, 700))};
                vals[REG_BITRATE_DOWN_LIMIT] = {$urandom, 32'($urandom_range(0, 8000000))};
                vals[REG_BITRATE_UP_LIMIT]   = {$urandom, 32'($urandom_range(1000000, 60000000))};
                vals[REG_FRAME_COUNTS]       = {$urandom, 16'($urandom),
                                                8'($urandom_range(0, 6)), 8'($urandom_range(0, 6))};
                vals[REG_BITRATE_FLOOR]      = {$urandom, 32'($urandom_range(0, 2000000))};
                vals[REG_NATIVE_SIZE]        = {$urandom, $urandom};
                vals[REG_FLOOR_SIZE]         = {$urandom, 16'($urandom_range(0, 3000)),
                                                16'($urandom_range(0, 3000))};
                vals[REG_SCALE_TABLE]        = {16'($urandom), 16'($urandom), 16'($urandom),
                                                $urandom_range(0, 1) ? 16'h8000 : 16'($urandom)};
                foreach (vals[i])
                    if ($urandom_range(0, 4) == 0) vals[i] = {$urandom, $urandom};
            end
        endcase
        for (int i = REG_LOAD_THRESHOLDS; i <= REG_SCALE_TABLE; i++)
            write_reg(4'(i), vals[i]);
        write_reg(4'($urandom_range(REG_SCALE_TABLE + 1, (1 << CFG_INDEX_W) - 1)),
                  {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in make_frame(t_push push);
        t_in         f;
        logic [63:0] knee;
        logic [15:0] thr;
        f.encode_time_us   = 20'($urandom);
        f.frame_budget_us  = 20'($urandom_range(1, 20'hFFFFF));
        f.measured_bitrate = $urandom;
        case (push)
            PUSH_DOWN: begin
                if ($urandom_range(0, 1) == 1) begin
                    knee = ((64'(cfg_load_thr[15:0]) * 64'(f.frame_budget_us)) >> 8)
                           + 64'($urandom_range(1, 4000));
                    f.encode_time_us = (knee > 64'hFFFFF) ? 20'hFFFFF : knee[19:0];
                end else begin
                    f.measured_bitrate = $urandom_range(1, cfg_down_limit);
                end
            end
            PUSH_UP: begin
                knee = (64'(cfg_load_thr[31:16]) * 64'(f.frame_budget_us)) >> 8;
                if (knee > 64'hFFFFF) knee = 64'hFFFFF;
                f.encode_time_us   = 20'((knee * 64'($urandom_range(0, 7))) / 8);
                f.measured_bitrate = $urandom_range(cfg_up_limit, 32'hFFFF_FFFF);
            end
            PUSH_KNEE: begin
                // budget a multiple of 256 so the exact tie is reachable
                f.frame_budget_us = 20'($urandom_range(1, 4095) << 8);
                thr  = $urandom_range(0, 1) ? cfg_load_thr[15:0] : cfg_load_thr[31:16];
                knee = ((64'(thr) * 64'(f.frame_budget_us)) >> 8)
                       + 64'($urandom_range(0, 2)) - 64'd1;
                f.encode_time_us = (knee > 64'hFFFFF) ? 20'hFFFFF : knee[19:0];
            end
            default: begin
                f.frame_budget_us = 20'($urandom);
                if ($urandom_range(0, 3) == 0) f.frame_budget_us = '0;
                if ($urandom_range(0, 7) == 0) f.measured_bitrate = '0;
            end
        endcase
        return f;
    endfunction

    task automatic run_phase(t_phase kind, int count, int odds);
        int    sent;
        int    pick;
        t_push push;
        idle_odds = odds;
        program_phase(kind);
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 19);
            push = (pick < 7) ? PUSH_DOWN : (pick < 14) ? PUSH_UP :
                   (pick < 17) ? PUSH_KNEE : PUSH_NOISE;
            // runs of one kind so streaks actually build up
            repeat ($urandom_range(1, 10)) begin
                offer_frame(make_frame(push), 1'b0, '0);
                sender_gap();
                sent++;
                if (frames_sent == HOLD_AT_FRAME) hold_request = 1'b1;
            end
        end
    endtask

    function automatic t_row frame_row(logic [19:0] t, logic [19:0] b, logic [31:0] rate);
        t_row r;
        r.kind         = ROW_FRAME;
        r.reg_index    = '0;
        r.reg_value    = '0;
        r.frame        = '{encode_time_us: t, frame_budget_us: b, measured_bitrate: rate};
        r.typed_result = '0;
        return r;
    endfunction

    function automatic t_row typed_row(logic [19:0] t, logic [19:0] b, logic [31:0] rate,
                                       t_out want);
        t_row r;
        r = frame_row(t, b, rate);
        r.kind         = ROW_TYPED;
        r.typed_result = want;
        return r;
    endfunction

    function automatic t_row reg_row(logic [3:0] idx, logic [63:0] value);
        t_row r;
        r = frame_row('0, '0, '0);
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.reg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register defaults: 1920x1080 native, factors 1.0 / 0.75 / 2/3 / 0.5
        directed_rows.push_back(typed_row(20'h0, 20'h0, 32'h0,
            t_out'{2'd0, 1'b0, 16'd1920, 16'd1080, 32'd500000}));
        directed_rows.push_back(typed_row(20'hFFFFF, 20'hFFFFF, 32'hFFFF_FFFF,
            t_out'{2'd0, 1'b0, 16'd1920, 16'd1080, 32'hFFFF_FFFF}));
        // step-up wish already at native level
        directed_rows.push_back(typed_row(20'h0, 20'hFFFFF, 32'hFFFF_FFFF,
            t_out'{2'd0, 1'b0, 16'd1920, 16'd1080, 32'hFFFF_FFFF}));
        // low bitrate streak of three moves the level
        directed_rows.push_back(frame_row(20'd0, 20'd1, 32'd1999999));
        directed_rows.push_back(frame_row(20'd0, 20'd1, 32'd1));
        directed_rows.push_back(frame_row(20'd0, 20'd1, 32'd1999999));
        directed_rows.push_back(frame_row(20'd1000, 20'd1000, 32'd3000000));
        // load exactly at the up threshold is not low load
        directed_rows.push_back(frame_row(20'd500, 20'd1000, 32'd5000000));
        directed_rows.push_back(reg_row(REG_FRAME_COUNTS, 64'h0100));
        directed_rows.push_back(frame_row(20'd1000, 20'd1000, 32'd3000000));
        directed_rows.push_back(frame_row(20'hFFFFF, 20'd1, 32'd0));
        directed_rows.push_back(frame_row(20'hFFFFF, 20'd1, 32'd0));
        directed_rows.push_back(frame_row(20'd0, 20'd0, 32'hFFFF_FFFF));
        directed_rows.push_back(frame_row(20'd499, 20'd1000, 32'd5000000));
        directed_rows.push_back(frame_row(20'd500, 20'd1000, 32'd5000000));
        directed_rows.push_back(frame_row(20'd499, 20'd1000, 32'd4999999));
        // both wishes at once: down pressure wins
        directed_rows.push_back(reg_row(REG_BITRATE_UP_LIMIT, 64'd1000000));
        directed_rows.push_back(frame_row(20'd0, 20'd1, 32'd1500000));
        directed_rows.push_back(reg_row(REG_SCALE_TABLE, '1));
        directed_rows.push_back(reg_row(REG_NATIVE_SIZE, '1));
        directed_rows.push_back(reg_row(REG_FLOOR_SIZE, '0));
        directed_rows.push_back(reg_row(REG_BITRATE_FLOOR, '0));
        directed_rows.push_back(typed_row(20'd0, 20'd0, 32'hFFFF_FFFF,
            t_out'{2'd1, 1'b1, 16'd65534, 16'd65534, 32'hFFFF_FFFF}));
        directed_rows.push_back(reg_row(REG_SCALE_TABLE, '0));
        directed_rows.push_back(reg_row(REG_LOAD_THRESHOLDS, '0));
        directed_rows.push_back(reg_row(REG_FLOOR_SIZE, 64'hFFFF_FFFF));
        directed_rows.push_back(reg_row(REG_UNMAPPED, '1));
        // zero budget with zero up threshold: no wish at all
        directed_rows.push_back(typed_row(20'hFFFFF, 20'd0, 32'hFFFF_FFFF,
            t_out'{2'd1, 1'b0, 16'hFFFF, 16'hFFFF, 32'd0}));
        directed_rows.push_back(typed_row(20'd1, 20'hFFFFF, 32'd0,
            t_out'{2'd2, 1'b1, 16'hFFFF, 16'hFFFF, 32'd0}));

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                drain_frames();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end else begin
                i_cfg_valid <= 1'b0;
                offer_frame(directed_rows[i].frame, directed_rows[i].kind == ROW_TYPED,
                            directed_rows[i].typed_result);
                sender_gap();
            end
        end

        run_phase(PHASE_DEFAULTS, 150, 4);
        run_phase(PHASE_RANDOM,   150, 3);
        run_phase(PHASE_RANDOM,   150, 0);   // long receiver hold lands here
        run_phase(PHASE_ZEROS,     60, 4);
        run_phase(PHASE_RANDOM,   150, 5);
        run_phase(PHASE_ONES,      60, 3);
        run_phase(PHASE_RANDOM,   150, 4);
        run_phase(PHASE_RANDOM,   150, 2);
        run_phase(PHASE_RANDOM,   130, 0);

        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    task automatic report(string field, logic [63:0] want, logic [63:0] got);
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
        mismatches++;
    endtask

    initial begin : result_sink
        t_out want;
        int   stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with none outstanding, expected nothing, got %0h",
                             $time, o_out_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.quality_level !== want.quality_level)
                        report("quality_level", want.quality_level, o_out_data.quality_level);
                    if (o_out_data.level_changed !== want.level_changed)
                        report("level_changed", want.level_changed, o_out_data.level_changed);
                    if (o_out_data.target_width !== want.target_width)
                        report("target_width", want.target_width, o_out_data.target_width);
                    if (o_out_data.target_height !== want.target_height)
                        report("target_height", want.target_height, o_out_data.target_height);
                    if (o_out_data.target_bitrate !== want.target_bitrate)
                        report("target_bitrate", want.target_bitrate, o_out_data.target_bitrate);
                end
            end
            // back-pressure long enough to fill the block while the sender keeps going
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

endmodule
